[rtl/hram_pkg.sv]
package hram_pkg;

  // Fixed-point format of the ratio and the averages
  localparam int FRAC_BITS = 16;
  localparam int RATIO_W   = FRAC_BITS + 1;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_BITS;

  // Counter and divider widths
  localparam int CNT_W  = 64;
  localparam int SUM_W  = CNT_W + 1;
  localparam int REM_W  = CNT_W + 2;
  localparam int ITER_W = $clog2(RATIO_W + 1);

  // Sample windows and count widths
  localparam int NS_W = 4;
  localparam int NM_W = 7;
  localparam int NL_W = 10;
  localparam logic [NS_W-1:0] WINDOW_SHORT = NS_W'(10);
  localparam logic [NM_W-1:0] WINDOW_MID   = NM_W'(100);
  localparam logic [NL_W-1:0] WINDOW_LONG  = NL_W'(1000);

  // Stream payload widths
  localparam int IN_W   = 2 * CNT_W;
  localparam int USER_W = 2;
  localparam int RES_W  = 4 * RATIO_W + NS_W + NM_W + NL_W;
  localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

  // Microcode
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_DELTA,
    OP_RSETUP,
    OP_DSTEP,
    OP_RDONE,
    OP_ASETUP,
    OP_ADONE,
    OP_OUT,
    OP_REINIT
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_REINIT,
    C_TRIV,
    C_LOOP
  } cond_t;

  typedef enum logic [1:0] {
    SEL_SHORT,
    SEL_MID,
    SEL_LONG
  } avg_sel_t;

  typedef struct packed {
    op_t             op;
    avg_sel_t        sel;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // Divider control from the sequencer
  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // Step addresses that jumps refer to
  localparam logic [PC_W-1:0] PC_WAIT   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_RDSTEP = PC_W'(3);
  localparam logic [PC_W-1:0] PC_AVG0   = PC_W'(5);
  localparam logic [PC_W-1:0] PC_DSTEP0 = PC_W'(6);
  localparam logic [PC_W-1:0] PC_DSTEP1 = PC_W'(9);
  localparam logic [PC_W-1:0] PC_DSTEP2 = PC_W'(12);
  localparam logic [PC_W-1:0] PC_OUT    = PC_W'(14);
  localparam logic [PC_W-1:0] PC_REINIT = PC_W'(15);

  // Control program: one word per step
  function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_WAIT, sel: SEL_SHORT, cond: C_NONE, target: PC_WAIT};
    case (pc)
      4'd0:  w = '{OP_WAIT,   SEL_SHORT, C_NONE,   PC_WAIT};
      4'd1:  w = '{OP_DELTA,  SEL_SHORT, C_REINIT, PC_REINIT};
      4'd2:  w = '{OP_RSETUP, SEL_SHORT, C_TRIV,   PC_AVG0};
      4'd3:  w = '{OP_DSTEP,  SEL_SHORT, C_LOOP,   PC_RDSTEP};
      4'd4:  w = '{OP_RDONE,  SEL_SHORT, C_NONE,   PC_WAIT};
      4'd5:  w = '{OP_ASETUP, SEL_SHORT, C_NONE,   PC_WAIT};
      4'd6:  w = '{OP_DSTEP,  SEL_SHORT, C_LOOP,   PC_DSTEP0};
      4'd7:  w = '{OP_ADONE,  SEL_SHORT, C_NONE,   PC_WAIT};
      4'd8:  w = '{OP_ASETUP, SEL_MID,   C_NONE,   PC_WAIT};
      4'd9:  w = '{OP_DSTEP,  SEL_MID,   C_LOOP,   PC_DSTEP1};
      4'd10: w = '{OP_ADONE,  SEL_MID,   C_NONE,   PC_WAIT};
      4'd11: w = '{OP_ASETUP, SEL_LONG,  C_NONE,   PC_WAIT};
      4'd12: w = '{OP_DSTEP,  SEL_LONG,  C_LOOP,   PC_DSTEP2};
      4'd13: w = '{OP_ADONE,  SEL_LONG,  C_NONE,   PC_WAIT};
      4'd14: w = '{OP_OUT,    SEL_SHORT, C_ALWAYS, PC_WAIT};
      4'd15: w = '{OP_REINIT, SEL_SHORT, C_ALWAYS, PC_OUT};
      default: w = '{OP_WAIT, SEL_SHORT, C_NONE, PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

[rtl/hram_div.sv]
module hram_div (
  input  logic                            clk,
  input  hram_pkg::div_ctl_t              ctl,
  input  logic [hram_pkg::REM_W-1:0]      rem_init,
  input  logic [hram_pkg::RATIO_W-1:0]    dvd_init,
  input  logic [hram_pkg::SUM_W-1:0]      divisor,
  output logic [hram_pkg::RATIO_W-1:0]    quo
);
  import hram_pkg::*;

  logic [REM_W-1:0]   rem;
  logic [RATIO_W-1:0] dvd;
  logic [SUM_W-1:0]   dv;
  logic [REM_W-1:0]   trial;
  logic               ge;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem[REM_W-2:0], dvd[RATIO_W-1]};
  assign ge    = trial >= {1'b0, dv};

  // Restoring division, one quotient bit per step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= rem_init;
      dvd <= dvd_init;
      dv  <= divisor;
      quo <= '0;
    end else if (ctl.step) begin
      rem <= ge ? trial - {1'b0, dv} : trial;
      dvd <= {dvd[RATIO_W-2:0], 1'b0};
      quo <= {quo[RATIO_W-2:0], ge};
    end
  end

endmodule

[rtl/hit_ratio_average_monitor_unit.sv]
// Channel  Dir  Beat contents
// s_*      in   tdata: hit_count, miss_count; tuser: req_type, avg_restart
// m_*      out  tdata: ratio, avg_short, avg_mid, avg_long, count_short/mid/long
//
// A sample runs the restoring divider one step per cycle, 16 steps for the ratio
// and 17 for each average; the ratio division is skipped when the miss delta is
// zero. A reinit item runs no division. The microcode step counter sets the pace.
// Reset (rst, synchronous) clears the baseline, the counts and the averages.
// A result waits in the output register; the next sample is accepted meanwhile,
// and the sequencer holds at its output step until that register is free.
module hit_ratio_average_monitor_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata: hit_count[63:0], miss_count[127:64]
  input  logic [hram_pkg::IN_W-1:0]     s_tdata,
  // tuser: req_type[0], avg_restart[1]
  input  logic [hram_pkg::USER_W-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tdata: ratio[16:0], avg_short[33:17], avg_mid[50:34], avg_long[67:51],
  //        count_short[71:68], count_mid[78:72], count_long[88:79], zeros above
  output logic [hram_pkg::OUT_W-1:0]    m_tdata
);
  import hram_pkg::*;

  logic [PC_W-1:0]    pc;
  logic [PC_W-1:0]    pc_next;
  ctrl_word_t         cw;
  logic               take;
  logic               hold;
  logic [ITER_W-1:0]  cnt;

  logic               req;
  logic               rst_avg;
  logic [CNT_W-1:0]   hit_in;
  logic [CNT_W-1:0]   miss_in;
  logic [CNT_W-1:0]   last_hit;
  logic [CNT_W-1:0]   last_miss;
  logic [CNT_W-1:0]   dh;
  logic [CNT_W-1:0]   dm;
  logic [RATIO_W-1:0] ratio;
  logic [NS_W-1:0]    n_short;
  logic [NM_W-1:0]    n_mid;
  logic [NL_W-1:0]    n_long;
  logic [RATIO_W-1:0] acc_short;
  logic [RATIO_W-1:0] acc_mid;
  logic [RATIO_W-1:0] acc_long;
  logic               neg;

  logic [NL_W-1:0]    n_cur;
  logic [NL_W-1:0]    n_cap;
  logic [NL_W-1:0]    n_upd;
  logic [RATIO_W-1:0] acc_cur;
  logic [RATIO_W-1:0] diff;
  logic [SUM_W-1:0]   sum;

  div_ctl_t           dctl;
  logic [REM_W-1:0]   rem_init;
  logic [RATIO_W-1:0] dvd_init;
  logic [SUM_W-1:0]   divisor;
  logic [RATIO_W-1:0] quo;
  logic [RES_W-1:0]   res;

  assign cw       = rom_word(pc);
  assign s_tready = !rst && cw.op == OP_WAIT;

  // Decode the jump and stall conditions
  always_comb begin
    unique case (cw.cond)
      C_NONE:   take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_REINIT: take = req;
      C_TRIV:   take = dm == '0;
      C_LOOP:   take = cnt != ITER_W'(1);
      default:  take = 1'b0;
    endcase
    hold = (cw.op == OP_WAIT && !s_tvalid) || (cw.op == OP_OUT && m_tvalid && !m_tready);
    if (hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // Select the average that this step works on
  always_comb begin
    case (cw.sel)
      SEL_SHORT: begin
        n_cur   = NL_W'(n_short);
        n_cap   = NL_W'(WINDOW_SHORT);
        acc_cur = acc_short;
      end
      SEL_MID: begin
        n_cur   = NL_W'(n_mid);
        n_cap   = NL_W'(WINDOW_MID);
        acc_cur = acc_mid;
      end
      SEL_LONG: begin
        n_cur   = n_long;
        n_cap   = WINDOW_LONG;
        acc_cur = acc_long;
      end
      default: begin
        n_cur   = n_long;
        n_cap   = WINDOW_LONG;
        acc_cur = acc_long;
      end
    endcase
    n_upd = (n_cur < n_cap) ? n_cur + NL_W'(1) : n_cur;
    diff  = (ratio >= acc_cur) ? ratio - acc_cur : acc_cur - ratio;
    sum   = {1'b0, dh} + {1'b0, dm};
  end

  // Drive the divider
  always_comb begin
    dctl.load = cw.op == OP_RSETUP || cw.op == OP_ASETUP;
    dctl.step = cw.op == OP_DSTEP;
    if (cw.op == OP_RSETUP) begin
      rem_init = {2'b00, dh};
      dvd_init = '0;
      divisor  = sum;
    end else begin
      rem_init = '0;
      dvd_init = diff;
      divisor  = SUM_W'(n_upd);
    end
  end

  hram_div u_div (
    .clk      (clk),
    .ctl      (dctl),
    .rem_init (rem_init),
    .dvd_init (dvd_init),
    .divisor  (divisor),
    .quo      (quo)
  );

  assign res = {n_long, n_mid, n_short, acc_long, acc_mid, acc_short, ratio};

  // Sequencer, datapath registers and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_WAIT;
      m_tvalid  <= 1'b0;
      last_hit  <= '0;
      last_miss <= '0;
      n_short   <= '0;
      n_mid     <= '0;
      n_long    <= '0;
      acc_short <= '0;
      acc_mid   <= '0;
      acc_long  <= '0;
      cnt       <= '0;
    end else begin
      pc <= pc_next;
      if (m_tvalid && m_tready && cw.op != OP_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (cw.op)
        OP_WAIT: begin
          // capture the beat
          if (s_tvalid) begin
            hit_in  <= s_tdata[CNT_W-1:0];
            miss_in <= s_tdata[IN_W-1:CNT_W];
            req     <= s_tuser[0];
            rst_avg <= s_tuser[1];
          end
        end
        OP_DELTA: begin
          dh        <= hit_in - last_hit;
          dm        <= miss_in - last_miss;
          last_hit  <= hit_in;
          last_miss <= miss_in;
          if (rst_avg && !req) begin
            n_short <= '0;
            n_mid   <= '0;
            n_long  <= '0;
          end
        end
        OP_RSETUP: begin
          // zero miss delta: ratio is exactly 0 or 1.0
          ratio <= (dh == '0) ? '0 : RATIO_ONE;
          cnt   <= ITER_W'(FRAC_BITS);
        end
        OP_DSTEP: begin
          cnt <= cnt - ITER_W'(1);
        end
        OP_RDONE: begin
          ratio <= quo;
        end
        OP_ASETUP: begin
          neg <= ratio < acc_cur;
          cnt <= ITER_W'(RATIO_W);
          case (cw.sel)
            SEL_SHORT: n_short <= n_upd[NS_W-1:0];
            SEL_MID:   n_mid   <= n_upd[NM_W-1:0];
            default:   n_long  <= n_upd;
          endcase
        end
        OP_ADONE: begin
          case (cw.sel)
            SEL_SHORT: acc_short <= neg ? acc_cur - quo : acc_cur + quo;
            SEL_MID:   acc_mid   <= neg ? acc_cur - quo : acc_cur + quo;
            default:   acc_long  <= neg ? acc_cur - quo : acc_cur + quo;
          endcase
        end
        OP_OUT: begin
          if (!hold) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'(res);
          end
        end
        OP_REINIT: begin
          ratio     <= '0;
          n_short   <= '0;
          n_mid     <= '0;
          n_long    <= '0;
          acc_short <= '0;
          acc_mid   <= '0;
          acc_long  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Counts stay within their windows
  assert property (@(posedge clk) disable iff (rst)
    n_short <= WINDOW_SHORT && n_mid <= WINDOW_MID && n_long <= WINDOW_LONG)
    else $error("sample count beyond its window");

  // Averages never leave 0 .. 1.0
  assert property (@(posedge clk) disable iff (rst)
    acc_short <= RATIO_ONE && acc_mid <= RATIO_ONE && acc_long <= RATIO_ONE)
    else $error("running average out of range");

  // A divider step always has iterations left
  assert property (@(posedge clk) disable iff (rst)
    cw.op == OP_DSTEP |-> cnt != '0)
    else $error("divider stepped with no iterations left");

  // A posted result carries a ratio within range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[RATIO_W-1:0] <= RATIO_ONE)
    else $error("result ratio out of range");

  // An accepted sample starts the delta step next
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> cw.op == OP_DELTA)
    else $error("sequencer lost an accepted beat");

endmodule

[tb/sv/hram_tb_pkg.sv]
`timescale 1ns / 100ps

package hram_tb_pkg;

  // Request kinds carried in tuser bit 0
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_REINIT = 1'b1
  } req_kind_t;

  // Slave-side tuser layout, lowest bit last
  typedef struct packed {
    logic      avg_restart;
    req_kind_t req_type;
  } beat_user_t;

  // Master-side tdata layout, lowest field last in the declaration
  typedef struct packed {
    logic [hram_pkg::OUT_W-hram_pkg::RES_W-1:0] pad;
    logic [hram_pkg::NL_W-1:0]                  count_long;
    logic [hram_pkg::NM_W-1:0]                  count_mid;
    logic [hram_pkg::NS_W-1:0]                  count_short;
    logic [hram_pkg::RATIO_W-1:0]               avg_long;
    logic [hram_pkg::RATIO_W-1:0]               avg_mid;
    logic [hram_pkg::RATIO_W-1:0]               avg_short;
    logic [hram_pkg::RATIO_W-1:0]               ratio;
  } ratio_beat_t;

endpackage

[tb/sv/hram_stream_checker.sv]
`timescale 1ns / 100ps

module hram_stream_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  // tdata: hit_count, miss_count
  input  logic [hram_pkg::IN_W-1:0]   s_tdata,
  // tuser: req_type, avg_restart
  input  logic [hram_pkg::USER_W-1:0] s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  // tdata: ratio, avg_short, avg_mid, avg_long, count_short, count_mid, count_long
  input  logic [hram_pkg::OUT_W-1:0]  m_tdata,
  output int                          errors,
  output int                          pending
);
  import hram_pkg::*;
  import hram_tb_pkg::*;

  // Beats still owed by the block, oldest first
  ratio_beat_t beats_owed[$];

  // Mirror of the block state: counter baseline, counts and averages per window
  logic [CNT_W-1:0]   base_hit;
  logic [CNT_W-1:0]   base_miss;
  int unsigned        win_count[3];
  logic [RATIO_W-1:0] win_avg[3];

  function automatic int unsigned window_size(input int k);
    case (k)
      0:       return WINDOW_SHORT;
      1:       return WINDOW_MID;
      default: return WINDOW_LONG;
    endcase
  endfunction

  // Interval hit ratio in Q.16, exact floor over a 65-bit sum
  function automatic logic [RATIO_W-1:0] interval_ratio(input logic [CNT_W-1:0] dh,
                                                        input logic [CNT_W-1:0] dm);
    logic [SUM_W-1:0]            span;
    logic [CNT_W+FRAC_BITS:0]    scaled;
    logic [CNT_W+FRAC_BITS:0]    quot;
    span = {1'b0, dh} + {1'b0, dm};
    if (dh == '0 && dm == '0) return '0;
    if (dm == '0) return RATIO_ONE;
    scaled = {1'b0, dh, {FRAC_BITS{1'b0}}};
    quot = scaled / span;
    return quot[RATIO_W-1:0];
  endfunction

  // Advance the mirror by one accepted beat and queue its result
  task automatic predict_beat(input logic [IN_W-1:0] data, input beat_user_t user);
    logic [CNT_W-1:0]   hit_now;
    logic [CNT_W-1:0]   miss_now;
    logic [RATIO_W-1:0] ratio;
    int unsigned        step;
    ratio_beat_t        want;
    hit_now  = data[CNT_W-1:0];
    miss_now = data[IN_W-1:CNT_W];
    ratio    = '0;
    if (user.req_type == REQ_REINIT) begin
      for (int k = 0; k < 3; k++) begin
        win_count[k] = 0;
        win_avg[k]   = '0;
      end
    end else begin
      ratio = interval_ratio(hit_now - base_hit, miss_now - base_miss);
      for (int k = 0; k < 3; k++) begin
        if (user.avg_restart) win_count[k] = 0;
        if (win_count[k] < window_size(k)) win_count[k]++;
        // move toward the ratio by the truncated share
        if (ratio >= win_avg[k]) begin
          step = (ratio - win_avg[k]) / win_count[k];
          win_avg[k] = win_avg[k] + RATIO_W'(step);
        end else begin
          step = (win_avg[k] - ratio) / win_count[k];
          win_avg[k] = win_avg[k] - RATIO_W'(step);
        end
      end
    end
    base_hit  = hit_now;
    base_miss = miss_now;
    want = '0;
    want.ratio       = ratio;
    want.avg_short   = win_avg[0];
    want.avg_mid     = win_avg[1];
    want.avg_long    = win_avg[2];
    want.count_short = NS_W'(win_count[0]);
    want.count_mid   = NM_W'(win_count[1]);
    want.count_long  = NL_W'(win_count[2]);
    beats_owed.push_back(want);
  endtask

  task automatic report_bad(input string what, input ratio_beat_t want, input ratio_beat_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected ratio %0d avg %0d/%0d/%0d count %0d/%0d/%0d pad %0h",
               want.ratio, want.avg_short, want.avg_mid, want.avg_long,
               want.count_short, want.count_mid, want.count_long, want.pad);
      $display("  actual   ratio %0d avg %0d/%0d/%0d count %0d/%0d/%0d pad %0h",
               got.ratio, got.avg_short, got.avg_mid, got.avg_long,
               got.count_short, got.count_mid, got.count_long, got.pad);
    end
  endtask

  // Check result beats first, then predict input beats taken at the same edge
  always @(posedge clk) begin
    ratio_beat_t got;
    ratio_beat_t want;
    if (rst) begin
      base_hit  = '0;
      base_miss = '0;
      for (int k = 0; k < 3; k++) begin
        win_count[k] = 0;
        win_avg[k]   = '0;
      end
      beats_owed.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = ratio_beat_t'(m_tdata);
        if (beats_owed.size() == 0) begin
          report_bad("result beat with none outstanding", '0, got);
        end else begin
          want = beats_owed.pop_front();
          if (got.ratio !== want.ratio || got.avg_short !== want.avg_short ||
              got.avg_mid !== want.avg_mid || got.avg_long !== want.avg_long ||
              got.count_short !== want.count_short || got.count_mid !== want.count_mid ||
              got.count_long !== want.count_long || got.pad !== want.pad)
            report_bad("result beat mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready) predict_beat(s_tdata, beat_user_t'(s_tuser));
    end
    pending = beats_owed.size();
  end

endmodule

[tb/sv/hit_ratio_average_monitor_unit_test.sv]
`timescale 1ns / 100ps

module hit_ratio_average_monitor_unit_test;
  import hram_pkg::*;
  import hram_tb_pkg::*;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic [IN_W-1:0]     s_tdata  = '0;
  logic [USER_W-1:0]   s_tuser  = '0;
  logic                m_tready = 1'b0;
  logic                s_tready;
  logic                m_tvalid;
  logic [OUT_W-1:0]    m_tdata;

  int errors;
  int pending;

  // Idling on both sides; cleared for the closing stretch
  bit idle_on = 1'b1;
  int stall_left = 0;

  // Last counters sent, used to build plausible increments
  logic [CNT_W-1:0] hit_sent  = '0;
  logic [CNT_W-1:0] miss_sent = '0;

  int samples_sent = 0;
  int flagged_sent = 0;
  int reinits_sent = 0;

  always #5 clk = ~clk;

  hit_ratio_average_monitor_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  hram_stream_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(0, 15);
    end else begin
      m_tready = 1'b1;
    end
  end

  // Present one beat, with an optional gap ahead of it, and hold until taken
  task automatic send_beat(input req_kind_t kind, input logic [CNT_W-1:0] hit,
                           input logic [CNT_W-1:0] miss, input logic flag);
    beat_user_t user;
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 16);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    user.req_type    = kind;
    user.avg_restart = flag;
    s_tdata  = {miss, hit};
    s_tuser  = user;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    hit_sent  = hit;
    miss_sent = miss;
    if (kind == REQ_REINIT) begin
      reinits_sent++;
    end else begin
      samples_sent++;
      if (flag) flagged_sent++;
    end
  endtask

  // Drop valid and hold off until every result has come back
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly counter increments; some one-sided, large or arbitrary jumps
  task automatic random_sample(input bit allow_flag);
    logic [CNT_W-1:0] hit;
    logic [CNT_W-1:0] miss;
    logic flag;
    int pick;
    pick = $urandom_range(0, 99);
    hit  = hit_sent + CNT_W'($urandom_range(0, 1000));
    miss = miss_sent + CNT_W'($urandom_range(0, 1000));
    if (pick < 6) begin
      hit = hit_sent;
    end else if (pick < 12) begin
      miss = miss_sent;
    end else if (pick < 15) begin
      hit  = hit_sent;
      miss = miss_sent;
    end else if (pick < 25) begin
      hit = hit_sent + {$urandom, $urandom};
    end else if (pick < 35) begin
      hit  = {$urandom, $urandom};
      miss = {$urandom, $urandom};
    end
    flag = allow_flag && ($urandom_range(0, 19) == 0);
    send_beat(REQ_SAMPLE, hit, miss, flag);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero deltas, one-sided deltas, flags, wraps and extreme values
    send_beat(REQ_SAMPLE, 64'd0, 64'd0, 1'b0);
    send_beat(REQ_SAMPLE, 64'd100, 64'd0, 1'b0);
    send_beat(REQ_SAMPLE, 64'd100, 64'd100, 1'b0);
    send_beat(REQ_SAMPLE, 64'd150, 64'd150, 1'b0);
    send_beat(REQ_SAMPLE, 64'd151, 64'd153, 1'b1);
    send_beat(REQ_REINIT, '1, '1, 1'b1);
    send_beat(REQ_SAMPLE, 64'd4, 64'd2, 1'b0);
    send_beat(REQ_SAMPLE, 64'd3, 64'd1, 1'b0);
    send_beat(REQ_SAMPLE, 64'd2, 64'd2, 1'b0);
    send_beat(REQ_SAMPLE, 64'd3, 64'd2, 1'b0);
    send_beat(REQ_SAMPLE, 64'd3, 64'd1, 1'b0);
    send_beat(REQ_REINIT, 64'd0, 64'd0, 1'b0);
    send_beat(REQ_SAMPLE, 64'd1, 64'd2, 1'b0);
    send_beat(REQ_SAMPLE, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0);
    send_beat(REQ_SAMPLE, '1, 64'h8000_0000_0000_0000, 1'b0);
    send_beat(REQ_SAMPLE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
    send_beat(REQ_SAMPLE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_beat(REQ_REINIT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_beat(REQ_SAMPLE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_beat(REQ_SAMPLE, 64'd0, '1, 1'b0);
    wait_for_results();

    // Long run with no reinit or flag so every window saturates
    repeat (1020) random_sample(1'b0);

    // Mixed run with reinits and average resets
    for (int i = 0; i < 130; i++) begin
      if (i == 70) idle_on = 1'b0;
      if ($urandom_range(0, 11) == 0)
        send_beat(REQ_REINIT, {$urandom, $urandom}, {$urandom, $urandom},
                  1'($urandom_range(0, 1)));
      else
        random_sample(1'b1);
    end

    wait_for_results();
    repeat (100) @(posedge clk);

    $display("Covered %0d samples (%0d with averages reset) and %0d reinits,",
             samples_sent, flagged_sent, reinits_sent);
    $display("including wrapped and one-sided deltas and full window saturation.");
    if (errors == 0 && pending == 0) begin
      $display("[hit_ratio_average_monitor_unit] OK");
    end else begin
      $display("[hit_ratio_average_monitor_unit] ERROR");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #10_000_000;
    $display("[hit_ratio_average_monitor_unit] ERROR");
    $finish;
  end

endmodule
